FILE: hw/rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared sizes, types and state encoding of the keyed value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int ENTRIES = 128;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    typedef enum logic {
        OP_READ   = 1'b0,
        OP_UPDATE = 1'b1
    } kvt_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VWAIT,
        ST_DONE
    } kvt_state_t;

    // one port group of a table memory
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } kvt_ram_req_t;

endpackage

FILE: hw/rtl/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Scan sequencer with one shared key comparator; drives both table memories
// and holds the result register.
// ----------------------------------------------------------------------------
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [DATA_W-1:0] s_key,
    input  logic [DATA_W-1:0] s_new_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic              m_hit,
    output logic              m_rejected,
    output kvt_ram_req_t      key_req,
    input  logic [DATA_W-1:0] key_rdata,
    output kvt_ram_req_t      val_req,
    input  logic [DATA_W-1:0] val_rdata
);

    kvt_state_t        state_reg, state_next;
    kvt_op_t           op_reg, op_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_hit_reg, res_hit_next;
    logic              res_rej_reg, res_rej_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_rej_reg, m_rej_next;

    logic accept;
    logic cmp_hit;
    logic scan_more;
    logic out_free;

    assign accept    = s_valid && s_ready;
    // shared comparator: stored key read last cycle against the request key
    assign cmp_hit   = pend_reg && (key_rdata == key_reg);
    assign scan_more = (addr_reg < used_reg);
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_hit        = m_hit_reg;
    assign m_rejected   = m_rej_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_key == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_hit) begin
                    state_next = (op_reg == OP_READ) ? ST_VWAIT : ST_DONE;
                end else if (!scan_more) begin
                    state_next = ST_DONE;
                end
            end
            ST_VWAIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        used_next      = used_reg;
        res_value_next = res_value_reg;
        res_hit_next   = res_hit_reg;
        res_rej_next   = res_rej_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_hit_next     = m_hit_reg;
        m_rej_next     = m_rej_reg;
        key_req        = '0;
        val_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next        = kvt_op_t'(s_operation);
                    key_next       = s_key;
                    value_next     = s_new_value;
                    addr_next      = '0;
                    res_value_next = '0;
                    res_hit_next   = 1'b0;
                    res_rej_next   = (s_key == '0);
                end
            end
            ST_SCAN: begin
                if (cmp_hit) begin
                    res_hit_next = 1'b1;
                    if (op_reg == OP_READ) begin
                        val_req.re    = 1'b1;
                        val_req.raddr = cmp_idx_reg;
                    end else begin
                        val_req.we    = 1'b1;
                        val_req.waddr = cmp_idx_reg;
                        val_req.wdata = value_reg;
                    end
                end else if (scan_more) begin
                    key_req.re    = 1'b1;
                    key_req.raddr = addr_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    cmp_idx_next  = addr_reg[IDX_W-1:0];
                    addr_next     = addr_reg + CNT_W'(1);
                end else if (op_reg == OP_UPDATE) begin
                    // miss on update: append at the first free entry, or reject when full
                    if (used_reg < FULL_COUNT) begin
                        key_req.we    = 1'b1;
                        key_req.waddr = used_reg[IDX_W-1:0];
                        key_req.wdata = key_reg;
                        val_req.we    = 1'b1;
                        val_req.waddr = used_reg[IDX_W-1:0];
                        val_req.wdata = value_reg;
                        used_next     = used_reg + CNT_W'(1);
                    end else begin
                        res_rej_next = 1'b1;
                    end
                end
            end
            ST_VWAIT: begin
                res_value_next = val_rdata;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_hit_next   = res_hit_reg;
                    m_rej_next   = res_rej_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        addr_reg      <= addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_value_reg <= res_value_next;
        res_hit_reg   <= res_hit_next;
        res_rej_reg   <= res_rej_next;
        m_value_reg   <= m_value_next;
        m_hit_reg     <= m_hit_next;
        m_rej_reg     <= m_rej_next;
    end

endmodule

FILE: hw/rtl/keyed_value_table.sv
// ----------------------------------------------------------------------------
// keyed_value_table
// Key/value table filled from entry zero upward, searched by a linear scan.
// ----------------------------------------------------------------------------
// One request at a time: s_ready is high only while the block is idle. A
// request scans the used entries through the key memory's single read port,
// one stored key per cycle, up to all 128 entries of a full table; a key of
// zero is rejected without a scan. A read hit returns the stored value, a
// read miss returns zero, an update overwrites a matching key or appends at
// the first free entry, and an update of a new key into a full table, or any
// request with key zero, comes back with m_rejected set. The result waits in
// an output register, so the next request is taken while it is still
// unclaimed.
module keyed_value_table
    import kvt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [DATA_W-1:0] s_key,
    input  logic [DATA_W-1:0] s_new_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic              m_hit,
    output logic              m_rejected
);

    kvt_ram_req_t      key_req;
    kvt_ram_req_t      val_req;
    logic [DATA_W-1:0] key_rdata;
    logic [DATA_W-1:0] val_rdata;

    kvt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_key        (s_key),
        .s_new_value  (s_new_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_hit        (m_hit),
        .m_rejected   (m_rejected),
        .key_req      (key_req),
        .key_rdata    (key_rdata),
        .val_req      (val_req),
        .val_rdata    (val_rdata)
    );

    kvt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_req.we),
        .waddr (key_req.waddr),
        .wdata (key_req.wdata),
        .re    (key_req.re),
        .raddr (key_req.raddr),
        .rdata (key_rdata)
    );

    kvt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_req.we),
        .waddr (val_req.waddr),
        .wdata (val_req.wdata),
        .re    (val_req.re),
        .raddr (val_req.raddr),
        .rdata (val_rdata)
    );

`ifndef SYNTHESIS
    // an appended key always gets its value in the same entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        key_req.we |-> (val_req.we && (val_req.waddr == key_req.waddr)))
        else $error("key written without matching value write");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken during a scan");

    // a hit is never a rejection
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> !m_rejected)
        else $error("result both hit and rejected");

    // a nonzero value only comes with a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_value != '0)) |-> m_hit)
        else $error("value returned without a hit");
`endif

endmodule

FILE: test/keyed_value_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_value_table_tb
// Drives read and update requests into the key/value table and checks every
// result against a shadow copy of the table. A directed opening covers the
// empty table, key zero and the field extremes. Random traffic then fills the
// table with fresh keys, mixes in hits, misses and overwrites, and keeps going
// past the full point so that new keys get rejected. Sender gaps and receiver
// stalls change from phase to phase.
// ----------------------------------------------------------------------------
module keyed_value_table_tb;
    import kvt_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] read_value;
        logic              hit;
        logic              rejected;
    } lookup_result_t;

    // shadow copy of the table plus the queue of results still owed
    class kv_shadow;
        logic [DATA_W-1:0] key_mem [ENTRIES];
        logic [DATA_W-1:0] val_mem [ENTRIES];
        int                used;
        int                errors;
        lookup_result_t    owed_results[$];

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int find_key(logic [DATA_W-1:0] k);
            for (int i = 0; i < used; i++) begin
                if (key_mem[i] == k) return i;
            end
            return -1;
        endfunction

        function void note_request(kvt_op_t op, logic [DATA_W-1:0] k,
                                   logic [DATA_W-1:0] v);
            lookup_result_t r;
            int idx;
            r.read_value = '0;
            r.hit        = 1'b0;
            r.rejected   = 1'b0;
            if (k == '0) begin
                r.rejected = 1'b1;
            end else begin
                idx = find_key(k);
                if (op == OP_READ) begin
                    if (idx >= 0) begin
                        r.read_value = val_mem[idx];
                        r.hit        = 1'b1;
                    end
                end else if (idx >= 0) begin
                    val_mem[idx] = v;
                    r.hit        = 1'b1;
                end else if (used < ENTRIES) begin
                    key_mem[used] = k;
                    val_mem[used] = v;
                    used++;
                end else begin
                    r.rejected = 1'b1;
                end
            end
            owed_results.push_back(r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] value, logic hit, logic rejected);
            lookup_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result value=%h hit=%b rejected=%b",
                                 value, hit, rejected));
            end else begin
                want = owed_results.pop_front();
                if (value !== want.read_value)
                    report($sformatf("read_value %h, expected %h", value, want.read_value));
                if (hit !== want.hit)
                    report($sformatf("hit %b, expected %b", hit, want.hit));
                if (rejected !== want.rejected)
                    report($sformatf("rejected %b, expected %b", rejected, want.rejected));
            end
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_operation = 1'b0;
    logic [DATA_W-1:0] s_key       = '0;
    logic [DATA_W-1:0] s_new_value = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [DATA_W-1:0] m_read_value;
    logic              m_hit;
    logic              m_rejected;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    kv_shadow  table_shadow   = new();

    keyed_value_table DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_key        (s_key),
        .s_new_value  (s_new_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_hit        (m_hit),
        .m_rejected   (m_rejected)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: random stalls, check every accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                table_shadow.check_result(m_read_value, m_hit, m_rejected);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called right after a rising edge; valid stays up between back-to-back requests
    task send_request(kvt_op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= k;
        s_new_value <= v;
        do @(posedge aclk); while (!s_ready);
        table_shadow.note_request(op, k, v);
    endtask

    task send_random_request();
        int                pick;
        logic [DATA_W-1:0] k;
        kvt_op_t           op;
        pick = $urandom_range(99);
        op   = kvt_op_t'($urandom_range(1));
        if (pick < 40 || table_shadow.used == 0) begin
            // fresh key, so the table keeps filling
            do k = $urandom; while (k == '0 || table_shadow.find_key(k) >= 0);
            op = OP_UPDATE;
        end else if (pick < 75) begin
            k  = table_shadow.key_mem[$urandom_range(table_shadow.used - 1)];
            op = (pick < 60) ? OP_READ : OP_UPDATE;
        end else if (pick < 85) begin
            k  = $urandom;
            op = OP_READ;
        end else if (pick < 90) begin
            k = '0;
        end else begin
            k = ($urandom_range(1)) ? DATA_W'($urandom_range(4)) : $urandom;
        end
        send_request(op, k, $urandom);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, key zero, field extremes
        send_request(OP_READ,   32'h0000_0001, 32'h0000_0000);
        send_request(OP_READ,   32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_READ,   32'h0000_0001, 32'h1234_5678);
        send_request(OP_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 32'h0000_0001, 32'hA5A5_5A5A);
        send_request(OP_READ,   32'h0000_0001, 32'h0000_0000);
        send_request(OP_READ,   32'h8000_0000, 32'h0000_0000);
        send_request(OP_UPDATE, 32'h8000_0000, 32'h5A5A_A5A5);
        send_request(OP_READ,   32'h8000_0000, 32'h0000_0000);
        send_request(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_READ,   32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_READ,   32'h0000_0000, 32'h0000_0000);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 36 : 0;
            repeat (100) send_random_request();
        end

        s_valid <= 1'b0;
        while (table_shadow.owed_results.size() != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);

        if (table_shadow.errors == 0)
            $display("keyed_value_table regression: pass");
        else
            $display("keyed_value_table regression: fail");
        $finish;
    end

    // full table scans with 60 percent stalls stay far below this
    initial begin
        #2_000_000;
        $display("keyed_value_table regression: fail");
        $finish;
    end

endmodule
